// ----- design/situ_pkg.sv -----
// Shared types and constants of the sub-CPU interrupt and timer unit.
package situ_pkg;

    // Fixed field widths.
    localparam int CLK_W     = 9;
    localparam int SRC_W     = 3;
    localparam int LEVEL_W   = 3;
    localparam int TIMER_W   = 8;
    localparam int PEND_W    = 7;
    localparam int SW_OUT_W  = 12;

    // Interrupt sources and levels.
    localparam logic [SRC_W-1:0]  SRC_RESET     = 3'd0;
    localparam logic [SRC_W-1:0]  SRC_COUNT     = 3'd7;
    localparam int                TIMER_LEVEL   = 3;
    localparam int                FIRST_LEVEL   = 1;
    localparam int                LAST_LEVEL    = 6;
    localparam logic [PEND_W-1:0] PENDING_RESET = 7'b000_0001;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_RAISE   = 2'd1,
        REQ_SERVICE = 2'd2,
        REQ_LOAD    = 2'd3
    } situ_req_t;

    // Result kinds carried in the output tuser.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_EXEC  = 3'd1,
        ACT_RESET = 3'd2,
        ACT_TAKEN = 3'd3,
        ACT_HALT  = 3'd4
    } situ_action_t;

    // One decoded input beat.
    typedef struct packed {
        situ_req_t           req;
        logic [CLK_W-1:0]    clocks;
        logic [SRC_W-1:0]    source;
        logic [LEVEL_W-1:0]  mask;
        logic                halted;
        logic [TIMER_W-1:0]  load;
    } situ_item_t;

    // Input beat with its clocks split into whole prescaler periods and a remainder.
    typedef struct packed {
        situ_item_t          item;
        logic [CLK_W-1:0]    quot;
        logic [CLK_W-1:0]    rem;
    } situ_split_t;

    // One result beat.
    typedef struct packed {
        situ_action_t         action;
        logic [LEVEL_W-1:0]   level;
        logic [PEND_W-1:0]    pending;
        logic [TIMER_W-1:0]   timer;
        logic [SW_OUT_W-1:0]  stopwatch;
        logic                 fired;
    } situ_result_t;

endpackage

// ----- design/situ_split.sv -----
// Input register and the two-stage split of a beat's clocks by the prescale period.
module situ_split #(
    parameter int PRESCALE    = 384,
    parameter int HALT_CLOCKS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  situ_pkg::situ_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output situ_pkg::situ_split_t out_split
);

    localparam int CW          = situ_pkg::CLK_W;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = (1 << RECIP_SHIFT) / PRESCALE;
    localparam int PROD_W      = CW + RECIP_SHIFT;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 load1, load2, load3;
    situ_pkg::situ_item_t item1_reg, item2_reg;
    logic [CW-1:0]        qest2_reg;
    situ_pkg::situ_split_t split3_reg;

    logic [PROD_W-1:0]    recip_prod;
    logic [CW-1:0]        qest_next;
    logic [2*CW-1:0]      qp;
    logic [2*CW-1:0]      diff;
    logic [CW:0]          rem_est;
    situ_pkg::situ_split_t split_next;
    situ_pkg::situ_item_t item_sel;

    // Each stage takes a beat when it is empty or its own beat moves on.
    assign load3    = !v3_reg || out_ready;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    // A halted service counts a fixed number of clocks.
    always_comb
    begin
        item_sel = in_item;
        if (in_item.req == situ_pkg::REQ_SERVICE && in_item.halted)
            item_sel.clocks = CW'(HALT_CLOCKS);
    end

    // Quotient estimate by the reciprocal; low by at most one.
    assign recip_prod = PROD_W'(item1_reg.clocks) * PROD_W'(RECIP);
    assign qest_next  = recip_prod[RECIP_SHIFT +: CW];

    // Remainder from the estimate, corrected with one compare and subtract.
    always_comb
    begin
        qp      = {{CW{1'b0}}, qest2_reg} * (2 * CW)'(PRESCALE);
        diff    = {{CW{1'b0}}, item2_reg.clocks} - qp;
        rem_est = diff[CW:0];
        split_next.item = item2_reg;
        if (rem_est >= (CW + 1)'(PRESCALE))
        begin
            split_next.quot = qest2_reg + CW'(1);
            split_next.rem  = CW'(rem_est - (CW + 1)'(PRESCALE));
        end
        else
        begin
            split_next.quot = qest2_reg;
            split_next.rem  = rem_est[CW-1:0];
        end
    end

    // Valid flags of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= in_valid;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        if (load1 && in_valid)
            item1_reg <= item_sel;
        if (load2 && v1_reg)
        begin
            item2_reg <= item1_reg;
            qest2_reg <= qest_next;
        end
        if (load3 && v2_reg)
            split3_reg <= split_next;
    end

    assign out_valid = v3_reg;
    assign out_split = split3_reg;

endmodule

// ----- design/situ_core.sv -----
// Interrupt and timer state, the per-beat update and the result register.
module situ_core #(
    parameter int PRESCALE       = 384,
    parameter int STOPWATCH_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  situ_pkg::situ_split_t in_split,
    output logic                  out_valid,
    input  logic                  out_ready,
    output situ_pkg::situ_result_t out_result
);

    localparam int CW = situ_pkg::CLK_W;
    localparam int SW = STOPWATCH_BITS;

    logic [CW-1:0]                     prescale_reg, prescale_next;
    logic [SW-1:0]                     stopwatch_reg, stopwatch_next;
    logic [situ_pkg::TIMER_W-1:0]      countdown_reg, countdown_next;
    logic [situ_pkg::PEND_W-1:0]       pending_reg, pending_next;
    logic                              irq_en_reg;
    logic                              out_valid_reg;
    situ_pkg::situ_result_t            result_reg, result_next;

    logic                              in_fire;
    logic                              apply_clocks;
    logic [CW:0]                       total;
    logic                              carry;
    logic [CW-1:0]                     wraps;
    logic                              fired;
    logic                              found;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Prescaler, stopwatch and countdown advance for ticks and halted services.
    always_comb
    begin
        apply_clocks = (in_split.item.req == situ_pkg::REQ_TICK)
                    || (in_split.item.req == situ_pkg::REQ_SERVICE && in_split.item.halted);
        total = {1'b0, prescale_reg} + {1'b0, in_split.rem};
        carry = total >= (CW + 1)'(PRESCALE);
        if (!apply_clocks)
        begin
            wraps         = '0;
            prescale_next = prescale_reg;
        end
        else
        begin
            wraps = in_split.quot + CW'(carry);
            if (carry)
                prescale_next = CW'(total - (CW + 1)'(PRESCALE));
            else
                prescale_next = total[CW-1:0];
        end
        stopwatch_next = stopwatch_reg + SW'(wraps);
        fired          = 1'b0;
        countdown_next = countdown_reg;
        if (countdown_reg != '0 && apply_clocks)
        begin
            if (wraps >= CW'(countdown_reg))
            begin
                fired          = 1'b1;
                countdown_next = '0;
            end
            else
                countdown_next = countdown_reg - situ_pkg::TIMER_W'(wraps);
        end
        // A load beat replaces the countdown.
        if (in_split.item.req == situ_pkg::REQ_LOAD)
            countdown_next = in_split.item.load;
    end

    // Pending flags, service priority and the result beat.
    always_comb
    begin
        pending_next = pending_reg;
        if (fired && irq_en_reg)
            pending_next[situ_pkg::TIMER_LEVEL] = 1'b1;
        result_next.action = situ_pkg::ACT_NONE;
        result_next.level  = '0;
        found              = 1'b0;
        unique case (in_split.item.req)
            situ_pkg::REQ_TICK:
            begin
            end
            situ_pkg::REQ_RAISE:
            begin
                if (in_split.item.source < situ_pkg::SRC_COUNT)
                    pending_next[in_split.item.source] = 1'b1;
            end
            situ_pkg::REQ_LOAD:
            begin
            end
            situ_pkg::REQ_SERVICE:
            begin
                if (in_split.item.halted)
                    result_next.action = situ_pkg::ACT_HALT;
                else if (pending_reg[situ_pkg::SRC_RESET])
                begin
                    pending_next[situ_pkg::SRC_RESET] = 1'b0;
                    result_next.action = situ_pkg::ACT_RESET;
                end
                else
                begin
                    result_next.action = situ_pkg::ACT_EXEC;
                    for (int n = situ_pkg::FIRST_LEVEL; n <= situ_pkg::LAST_LEVEL; n++)
                    begin
                        if (!found && pending_reg[n]
                            && situ_pkg::LEVEL_W'(n) > in_split.item.mask)
                        begin
                            found              = 1'b1;
                            pending_next[n]    = 1'b0;
                            result_next.action = situ_pkg::ACT_TAKEN;
                            result_next.level  = situ_pkg::LEVEL_W'(n);
                        end
                    end
                end
            end
        endcase
        result_next.pending   = pending_next;
        result_next.timer     = countdown_next;
        result_next.stopwatch = situ_pkg::SW_OUT_W'(stopwatch_next);
        result_next.fired     = fired;
    end

    // State, enable register and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= '0;
            stopwatch_reg <= '0;
            countdown_reg <= '0;
            pending_reg   <= situ_pkg::PENDING_RESET;
            irq_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                irq_en_reg <= cfg_wdata;
            if (in_fire)
            begin
                prescale_reg  <= prescale_next;
                stopwatch_reg <= stopwatch_next;
                countdown_reg <= countdown_next;
                pending_reg   <= pending_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

`ifndef SYNTH
    // The prescaler always stays below one period.
    a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_reg < CW'(PRESCALE))
        else $error("prescaler reached its period");

    // A fired countdown reports zero.
    a_fired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.fired |-> result_reg.timer == '0)
        else $error("timer fired with nonzero count");

    // Only a taken interrupt reports a level, and that level is no longer pending.
    a_level_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.action == situ_pkg::ACT_TAKEN
            ? (result_reg.level != '0 && !result_reg.pending[result_reg.level])
            : result_reg.level == '0))
        else $error("taken level inconsistent with action");

    // A reset vector load leaves the reset source clear.
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.action == situ_pkg::ACT_RESET
        |-> !result_reg.pending[situ_pkg::SRC_RESET])
        else $error("reset source still pending after reset vector load");

    // A load beat sets the countdown to the loaded value.
    a_load_timer: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_split.item.req == situ_pkg::REQ_LOAD
        |=> countdown_reg == $past(in_split.item.load))
        else $error("countdown not loaded");
`endif

endmodule

// ----- design/subcpu_interrupt_and_timer_unit_core.sv -----
// Top level of the sub-CPU interrupt and timer unit: stream ports and beat packing.
//
// The unit keeps seven pending interrupt flags, a clock prescaler, a
// free-running stopwatch and an 8-bit countdown timer. Each input beat is a
// tick, an interrupt raise, a service attempt or a countdown load, chosen by
// s_tuser, and each input beat gives exactly one result beat on the master
// side, in order. The result reports the service action, the level taken,
// and the pending flags, countdown and stopwatch after the beat.
// A beat passes the input register, the reciprocal multiply that counts whole
// prescaler periods and the remainder correction, then the state update that
// writes the result register. One beat is accepted in every cycle while the
// receiver does not stall; the single state update stage bounds that rate.
// While the receiver stalls, the result register holds its beat and the
// three leading stages still fill, so s_tready drops only once all of them
// are occupied. The user must write the enable of the timer interrupt
// through cfg_we and cfg_wdata only while the unit is idle; the block
// itself does not enforce this. Reset clears the prescaler, stopwatch and
// countdown, leaves only the reset source pending and disables the timer
// interrupt.
module subcpu_interrupt_and_timer_unit_core #(
    parameter int PRESCALE       = 384,
    parameter int STOPWATCH_BITS = 12,
    parameter int HALT_CLOCKS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // clock_count[8:0], source[11:9], mask_level[14:12], halted[15], timer_load[23:16]
    input  logic [23:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // taken_level[2:0], pending_flags[9:3], timer_value[17:10],
    // stopwatch_value[29:18], timer_fired[30], zero fill[31]
    output logic [31:0] m_tdata,
    // action[2:0]
    output logic [2:0]  m_tuser
);

    situ_pkg::situ_item_t   in_item;
    situ_pkg::situ_split_t  split;
    situ_pkg::situ_result_t result;
    logic                   split_valid;
    logic                   split_ready;

    // Unpack the input beat.
    always_comb
    begin
        in_item.req    = situ_pkg::situ_req_t'(s_tuser);
        in_item.clocks = s_tdata[8:0];
        in_item.source = s_tdata[11:9];
        in_item.mask   = s_tdata[14:12];
        in_item.halted = s_tdata[15];
        in_item.load   = s_tdata[23:16];
    end

    situ_split #(
        .PRESCALE    (PRESCALE),
        .HALT_CLOCKS (HALT_CLOCKS)
    ) u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_split (split)
    );

    situ_core #(
        .PRESCALE       (PRESCALE),
        .STOPWATCH_BITS (STOPWATCH_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (split_valid),
        .in_ready   (split_ready),
        .in_split   (split),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result beat.
    assign m_tdata = {1'b0, result.fired, result.stopwatch, result.timer,
                      result.pending, result.level};
    assign m_tuser = result.action;

endmodule

// ----- tb/situ_beat_checker.sv -----
// Checker for the sub-CPU interrupt and timer unit: predicts every result beat and compares it.
module situ_beat_checker #(
    parameter int PRESCALE       = 384,
    parameter int STOPWATCH_BITS = 12,
    parameter int HALT_CLOCKS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          outstanding
);

    // Shadow copy of the unit's state and its one register.
    logic [situ_pkg::CLK_W-1:0]   presc_cnt;
    logic [STOPWATCH_BITS-1:0]    sw_count;
    logic [situ_pkg::TIMER_W-1:0] countdown_val;
    logic [situ_pkg::PEND_W-1:0]  pend_flags;
    logic                         tmr_irq_en;

    situ_pkg::situ_result_t expected_results[$];
    int                     fails;

    // Adds clocks to the prescaler and handles each wrap in turn.
    // Returns 1 when the countdown reached zero on one of the wraps.
    function automatic logic advance_prescaler(int unsigned clocks);
        int unsigned total;
        logic        fired;
        fired = 1'b0;
        total = presc_cnt + clocks;
        while (total >= PRESCALE)
        begin
            total    -= PRESCALE;
            sw_count  = sw_count + 1'b1;
            if (countdown_val != '0)
            begin
                countdown_val = countdown_val - 1'b1;
                if (countdown_val == '0)
                begin
                    fired = 1'b1;
                    if (tmr_irq_en)
                        pend_flags[situ_pkg::TIMER_LEVEL] = 1'b1;
                end
            end
        end
        presc_cnt = situ_pkg::CLK_W'(total);
        return fired;
    endfunction

    // Applies one input beat to the shadow state and returns the result it must give.
    function automatic situ_pkg::situ_result_t predict_service_result(
        situ_pkg::situ_item_t item);
        situ_pkg::situ_result_t res;
        int                     lvl;
        res        = '0;
        res.action = situ_pkg::ACT_NONE;
        case (item.req)
            situ_pkg::REQ_TICK:
                res.fired = advance_prescaler(32'(item.clocks));
            situ_pkg::REQ_RAISE:
                if (item.source != situ_pkg::SRC_COUNT)
                    pend_flags[item.source] = 1'b1;
            situ_pkg::REQ_LOAD:
                countdown_val = item.load;
            default:
            begin
                if (item.halted)
                begin
                    // A halted processor only lets time pass; nothing is taken.
                    res.fired  = advance_prescaler(HALT_CLOCKS);
                    res.action = situ_pkg::ACT_HALT;
                end
                else if (pend_flags[situ_pkg::SRC_RESET])
                begin
                    pend_flags[situ_pkg::SRC_RESET] = 1'b0;
                    res.action                      = situ_pkg::ACT_RESET;
                end
                else
                begin
                    // Lowest pending level above the mask wins.
                    res.action = situ_pkg::ACT_EXEC;
                    for (lvl = situ_pkg::FIRST_LEVEL; lvl <= situ_pkg::LAST_LEVEL; lvl++)
                    begin
                        if (res.action == situ_pkg::ACT_EXEC && pend_flags[lvl]
                            && lvl > item.mask)
                        begin
                            pend_flags[lvl] = 1'b0;
                            res.action      = situ_pkg::ACT_TAKEN;
                            res.level       = situ_pkg::LEVEL_W'(lvl);
                        end
                    end
                end
            end
        endcase
        res.pending   = pend_flags;
        res.timer     = countdown_val;
        res.stopwatch = situ_pkg::SW_OUT_W'(sw_count);
        return res;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // Watch both channels and the register port on every clock edge.
    always @(posedge clk or negedge rst_n)
    begin : beat_watch
        situ_pkg::situ_item_t   item;
        situ_pkg::situ_result_t want;
        if (!rst_n)
        begin
            presc_cnt     = '0;
            sw_count      = '0;
            countdown_val = '0;
            pend_flags    = situ_pkg::PENDING_RESET;
            tmr_irq_en    = 1'b0;
            fails         = 0;
            expected_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                tmr_irq_en = cfg_wdata;

            // Result beat: compare with the oldest expectation.
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("action", 32'(want.action), 32'(m_tuser));
                    check_field("taken_level", 32'(want.level), 32'(m_tdata[2:0]));
                    check_field("pending_flags", 32'(want.pending), 32'(m_tdata[9:3]));
                    check_field("timer_value", 32'(want.timer), 32'(m_tdata[17:10]));
                    check_field("stopwatch_value", 32'(want.stopwatch), 32'(m_tdata[29:18]));
                    check_field("timer_fired", 32'(want.fired), 32'(m_tdata[30]));
                end
            end

            // Input beat: predict its result.
            if (s_tvalid && s_tready)
            begin
                item.req    = situ_pkg::situ_req_t'(s_tuser);
                item.clocks = s_tdata[8:0];
                item.source = s_tdata[11:9];
                item.mask   = s_tdata[14:12];
                item.halted = s_tdata[15];
                item.load   = s_tdata[23:16];
                expected_results.push_back(predict_service_result(item));
            end

            fail_count  <= fails;
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- tb/tb_subcpu_interrupt_and_timer_unit_core.sv -----
// Testbench top for the sub-CPU interrupt and timer unit: clock, reset, stimulus and verdict.
module tb_subcpu_interrupt_and_timer_unit_core;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ROLLOVER_RUN = 60;
    localparam int RANDOM_RUN   = 130;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    int fail_count;
    int outstanding;
    int cycle_cnt   = 0;
    int burst_left  = 0;
    int ready_mode  = 0;
    int ready_left  = 0;
    int ready_tick  = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    subcpu_interrupt_and_timer_unit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    situ_beat_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Receiver stalls: always ready, coin toss, mostly stalled, or a fixed one-in-five stall.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(32, 256);
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_tick % 5) != 0;
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[subcpu_interrupt_and_timer_unit_core] ERROR");
            $finish;
        end
    end

    // Sender pacing: bursts of random length separated by short gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap        = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Presents one beat and holds it until the unit accepts it.
    task automatic issue(situ_pkg::situ_req_t req, logic [8:0] clocks, logic [2:0] src,
                         logic [2:0] mask, logic halted, logic [7:0] load);
        pace_sender();
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {load, halted, mask, src, clocks};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops sending and waits until every result beat has come back.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_irq_enable(logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random beat; loads favor small values so the countdown often expires.
    task automatic issue_random();
        int                  pick;
        situ_pkg::situ_req_t req;
        logic [8:0]          clocks;
        logic [2:0]          src;
        logic [2:0]          mask;
        logic                halted;
        logic [7:0]          load;
        pick   = $urandom_range(0, 99);
        clocks = 9'($urandom);
        src    = 3'($urandom);
        mask   = 3'($urandom);
        halted = 1'($urandom);
        load   = 8'($urandom);
        if (pick < 40)
        begin
            req    = situ_pkg::REQ_TICK;
            clocks = ($urandom_range(0, 15) == 0) ? 9'($urandom_range(384, 511))
                                                  : 9'($urandom_range(0, 383));
        end
        else if (pick < 60)
        begin
            req = situ_pkg::REQ_RAISE;
        end
        else if (pick < 85)
        begin
            req    = situ_pkg::REQ_SERVICE;
            halted = ($urandom_range(0, 3) == 0);
        end
        else
        begin
            req = situ_pkg::REQ_LOAD;
            if ($urandom_range(0, 1))
                load = 8'($urandom_range(0, 6));
        end
        issue(req, clocks, src, mask, halted, load);
    endtask

    initial
    begin : stimulus
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset vector, empty service, source seven, masks, halt, timer.
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_RAISE, 9'd0, situ_pkg::SRC_COUNT, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_TICK, 9'd0, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_RAISE, 9'd0, 3'd6, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_RAISE, 9'd0, 3'd1, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_RAISE, 9'd0, 3'd3, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd7, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd6, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd2, 1'b0, 8'd0);
        issue(situ_pkg::REQ_RAISE, 9'd0, situ_pkg::SRC_RESET, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd0, 1'b1, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd5, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd5, 1'b0, 8'd0);
        issue(situ_pkg::REQ_LOAD, 9'd0, 3'd0, 3'd0, 1'b0, 8'd255);
        issue(situ_pkg::REQ_TICK, 9'd383, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_TICK, 9'd511, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_LOAD, 9'd0, 3'd0, 3'd0, 1'b0, 8'd1);
        issue(situ_pkg::REQ_TICK, 9'd384, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_LOAD, 9'd0, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_TICK, 9'd511, 3'd0, 3'd0, 1'b0, 8'd0);
        drain_stream();

        // With the timer interrupt enabled, expiry must raise level three.
        write_irq_enable(1'b1);
        issue(situ_pkg::REQ_LOAD, 9'd0, 3'd0, 3'd0, 1'b0, 8'd2);
        issue(situ_pkg::REQ_TICK, 9'd511, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_TICK, 9'd511, 3'd0, 3'd0, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd3, 1'b0, 8'd0);
        issue(situ_pkg::REQ_SERVICE, 9'd0, 3'd0, 3'd2, 1'b0, 8'd0);
        drain_stream();

        // Run of large ticks with a long countdown running.
        issue(situ_pkg::REQ_LOAD, 9'd0, 3'd0, 3'd0, 1'b0, 8'd255);
        repeat (ROLLOVER_RUN)
            issue(situ_pkg::REQ_TICK, 9'd511, 3'($urandom), 3'($urandom), 1'($urandom),
                  8'($urandom));
        drain_stream();

        // Random phases, alternating the timer interrupt enable.
        for (phase = 0; phase < 4; phase++)
        begin
            write_irq_enable(phase[0]);
            repeat (RANDOM_RUN)
                issue_random();
            drain_stream();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[subcpu_interrupt_and_timer_unit_core] OK");
        else
            $display("[subcpu_interrupt_and_timer_unit_core] ERROR");
        $finish;
    end

endmodule
